@@ hw/rtl/b2da_pkg.sv @@
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and types of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 6;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 10;
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // x / 10 == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;
    localparam int                 QUOT_W      = 2 * VALUE_W - RECIP_SHIFT;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

    // one converted value: digits least significant first, index of the top digit
    typedef struct packed {
        digit_vec_t       digits;
        logic [IDX_W-1:0] top;
    } entry_t;

endpackage

@@ hw/rtl/b2da_front.sv @@
// ----------------------------------------------------------------------------
// b2da_front
// Accepts a value and splits it into decimal digits, one digit per cycle.
// ----------------------------------------------------------------------------
module b2da_front import b2da_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,
    output logic               q_wr_valid,
    input  logic               q_wr_ready,
    output entry_t             q_wr_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [VALUE_W-1:0]   x_reg, x_next;
    logic [IDX_W-1:0]     step_reg, step_next;
    logic [IDX_W-1:0]     top_reg, top_next;
    digit_vec_t           digits_reg, digits_next;

    logic [2*VALUE_W-1:0] prod;
    logic [QUOT_W-1:0]    quot;
    logic [VALUE_W-1:0]   rem;
    logic [DIGIT_W-1:0]   digit;
    logic                 last_step;
    logic                 accept;

    assign prod      = (2*VALUE_W)'(x_reg) * (2*VALUE_W)'(RECIP_10);
    assign quot      = prod[2*VALUE_W-1:RECIP_SHIFT];
    assign rem       = x_reg - ((VALUE_W'(quot) << 3) + (VALUE_W'(quot) << 1));
    assign digit     = rem[DIGIT_W-1:0];
    assign last_step = (step_reg == IDX_W'(MAX_DIGITS - 1));

    always_comb begin
        digits_next        = digits_reg;
        digits_next[step_reg] = digit;
        top_next           = (digit != '0) ? step_reg : top_reg;
    end

    assign q_wr_valid = ((state_reg == ST_RUN) && last_step) || (state_reg == ST_HOLD);
    assign q_wr_data  = (state_reg == ST_RUN) ? entry_t'{digits: digits_next, top: top_next}
                                              : entry_t'{digits: digits_reg, top: top_reg};

    assign s_tready = (state_reg == ST_IDLE) || (q_wr_valid && q_wr_ready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                state_next = state_reg;
            end
            ST_RUN: begin
                x_next    = VALUE_W'(quot);
                step_next = step_reg + 1'b1;
                if (last_step) begin
                    state_next = q_wr_ready ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (q_wr_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (accept) begin
            state_next = ST_RUN;
            x_next     = s_tdata;
            step_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        step_reg <= step_next;
        if (accept) begin
            top_reg <= '0;
        end else if (state_reg == ST_RUN) begin
            digits_reg <= digits_next;
            top_reg    <= top_next;
        end
    end

endmodule

@@ hw/rtl/b2da_queue.sv @@
// ----------------------------------------------------------------------------
// b2da_queue
// Short FIFO of converted values between the digit splitter and the serializer.
// ----------------------------------------------------------------------------
module b2da_queue import b2da_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  entry_t wr_data,
    output logic   rd_valid,
    input  logic   rd_ready,
    output entry_t rd_data
);

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                push, pop;

    assign wr_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/b2da_back.sv @@
// ----------------------------------------------------------------------------
// b2da_back
// Serializes one converted value as ASCII digits, most significant first.
// ----------------------------------------------------------------------------
module b2da_back import b2da_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_rd_valid,
    output logic       q_rd_ready,
    input  entry_t     q_rd_data,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic       m_tlast
);

    logic             active_reg;
    logic [IDX_W-1:0] idx_reg;
    digit_vec_t       digits_reg;
    logic             load;

    assign m_tvalid   = active_reg;
    assign m_tlast    = (idx_reg == '0);
    assign m_tdata    = {2'b00, ASCII_ZERO + CHAR_W'(digits_reg[idx_reg])};
    assign q_rd_ready = !active_reg || (m_tready && m_tlast);
    assign load       = q_rd_valid && q_rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (load) begin
            active_reg <= 1'b1;
        end else if (m_tready && m_tlast) begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            digits_reg <= q_rd_data.digits;
            idx_reg    <= q_rd_data.top;
        end else if (active_reg && m_tready) begin
            idx_reg <= idx_reg - 1'b1;
        end
    end

endmodule

@@ hw/rtl/binary_to_decimal_ascii_core.sv @@
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Converts 32-bit unsigned values to decimal ASCII text, one digit per beat.
// ----------------------------------------------------------------------------
// Each value on the slave stream becomes its decimal digits as ASCII codes on
// the master stream, most significant digit first, without leading zeros; a
// zero value gives a single '0'. tlast marks the least significant digit.
// The splitter works through every digit position of a value, one digit per
// cycle through a reciprocal multiply by 1/10, and the serializer sends one
// character per cycle while m_tready is high. A two-entry queue between them
// lets a new value be split while the previous one is still being sent.
module binary_to_decimal_ascii_core import b2da_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic               m_tlast
);

    logic   q_wr_valid, q_wr_ready;
    logic   q_rd_valid, q_rd_ready;
    entry_t q_wr_data, q_rd_data;

    b2da_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_wr_valid (q_wr_valid),
        .q_wr_ready (q_wr_ready),
        .q_wr_data  (q_wr_data)
    );

    b2da_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    b2da_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_rd_valid (q_rd_valid),
        .q_rd_ready (q_rd_ready),
        .q_rd_data  (q_rd_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    a_char_is_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:4] == 4'h3) && (m_tdata[3:0] <= 4'd9))
        else $error("output character is not a decimal digit");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (MAX_DIGITS > 1) && s_tvalid && s_tready |=> !s_tready)
        else $error("splitter took a new value while still splitting");

    a_queue_top_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_rd_valid |-> (q_rd_data.top <= IDX_W'(MAX_DIGITS - 1)))
        else $error("queued top digit index out of range");

endmodule

@@ bench/tb_binary_to_decimal_ascii_core.sv @@
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii_core
// Self-checking bench for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Values go in on the slave stream. For each accepted value the bench works
// out the expected digit characters and their end marker. Every character on
// the master stream is compared with the oldest pending one. Directed values
// cover digit-count boundaries, the field extremes and inner and trailing
// zeros. Random phases then run under several sender and receiver idle
// patterns, and one long receiver hold-off fills the block until its input
// stalls.
module tb_binary_to_decimal_ascii_core;
    import b2da_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RADIX          = 10;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_LEN    = 200;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } digit_char_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata = '0;    // [31:0] value
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;         // [5:0] digit_char, [7:6] zero
    logic               m_tlast;

    digit_char_t pending_chars[$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          holdoff_left = 0;

    binary_to_decimal_ascii_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Split the value into decimal digits and queue them most significant first.
    function automatic void predict_decimal_chars(input logic [VALUE_W-1:0] value);
        logic [DIGIT_W-1:0] digits [MAX_DIGITS];
        logic [VALUE_W-1:0] rest;
        int                 top;
        digit_char_t        c;
        rest = value;
        top  = 0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            digits[i] = DIGIT_W'(rest % RADIX);
            rest      = rest / RADIX;
            if (digits[i] != '0) begin
                top = i;
            end
        end
        for (int i = top; i >= 0; i--) begin
            c.code = ASCII_ZERO + CHAR_W'(digits[i]);
            c.last = (i == 0);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom() >> $urandom_range(31);
            2: return $urandom_range(0, 120);
            default: return $urandom_range(1, 9) * 32'd1000000000 / (32'd1 << $urandom_range(4))
                            + $urandom_range(0, 9);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch %0s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
        mismatches++;
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_decimal_chars(value);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic test_digit_boundaries();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'd99);
        send_value(32'd100);
        send_value(32'd999999999);
        send_value(32'd1000000000);
        wait_drained();
    endtask

    task automatic test_extremes();
        send_value(32'hFFFF_FFFF);
        send_value(32'hFFFF_FFFE);
        send_value(32'h8000_0000);
        send_value(32'hAAAA_AAAA);
        send_value(32'h5555_5555);
        send_value(32'd123456789);
        send_value(32'd7);
        wait_drained();
    endtask

    task automatic test_inner_zeros();
        send_value(32'd101);
        send_value(32'd10000);
        send_value(32'd1000000007);
        send_value(32'd2000000002);
        send_value(32'd3000000000);
        send_value(32'd4000000000);
        send_value(32'd0);
        wait_drained();
    endtask

    task automatic test_random(input int src_pct, input int sink_pct, input int count);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (count) begin
            send_value(random_value());
        end
        wait_drained();
    endtask

    // Stop the receiver for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        holdoff_left   = HOLDOFF_LEN;
        repeat (12) begin
            send_value(32'hFFFF_FFFF - $urandom_range(0, 1000));
        end
        wait_drained();
    endtask

    always @(negedge aclk) begin
        if (holdoff_left > 0) begin
            m_tready     <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        digit_char_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("unexpected character", 0, 32'({m_tlast, m_tdata}));
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata[CHAR_W-1:0] !== want.code) begin
                    report_mismatch("digit_char", 32'(want.code), 32'(m_tdata[CHAR_W-1:0]));
                end
                if (m_tdata[7:CHAR_W] !== '0) begin
                    report_mismatch("tdata padding", 0, 32'(m_tdata[7:CHAR_W]));
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("tlast", 32'(want.last), 32'(m_tlast));
                end
            end
        end
    end

    // Count cycles with no transaction on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        test_digit_boundaries();
        test_extremes();
        test_inner_zeros();
        test_random(0, 0, 40);
        test_random(58, 0, 35);
        test_random(0, 58, 35);
        test_random(7, 7, 40);
        test_backpressure();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
